FILE: hw/rtl/ctus_pkg.sv
// ----------------------------------------------------------------------------
// ctus_pkg: shared constants and types for the civil time converter
// Calendar and clock constants, internal widths, the side-band word that
// travels down the pipeline and the day-of-year offset of each month.
// ----------------------------------------------------------------------------
package ctus_pkg;

  // Widths of the ports.
  localparam int FIELD_W = 32;
  localparam int SECS_W  = 64;

  // Calendar and clock constants.
  localparam int MONTHS_PER_YEAR = 12;
  localparam int YEARS_PER_ERA   = 400;
  localparam int DAYS_PER_ERA    = 146097;
  localparam int DAYS_PER_YEAR   = 365;
  localparam int EPOCH_DAYS      = 719468;
  localparam int SECS_PER_MINUTE = 60;
  localparam int SECS_PER_HOUR   = 3600;
  localparam int SECS_PER_DAY    = 86400;
  localparam int MARCH_INDEX     = 2;

  // A day is 675 * 128 seconds: a narrow product and a shift.
  localparam int DAY_MUL   = 675;
  localparam int DAY_SHIFT = 7;

  // Internal widths, sized to the extreme input values.
  localparam int MONTH_DIV_W = 33;
  localparam int ERA_DIV_W   = 34;
  localparam int ERA_W       = 26;
  localparam int ERA_DAYS_W  = 43;
  localparam int DAYS_W      = 44;
  localparam int DAY_PROD_W  = 54;
  localparam int DAY_ADJ_W   = 33;
  localparam int MIN_SECS_W  = 38;
  localparam int HOUR_SECS_W = 44;
  localparam int SOD_MIN_W   = 39;
  localparam int SOD_W       = 45;
  localparam int MIDX_W      = 4;
  localparam int YOE_W       = 9;
  localparam int DOY_W       = 9;
  localparam int DOE_W       = 18;

  // Side-band word carried alongside the calendar arithmetic.
  typedef struct packed {
    logic [DAY_ADJ_W-1:0] day_adj;
    logic [SOD_W-1:0]     secs;
    logic                 flag;
  } side_t;

  // Days from the first of March to the first of the given month, where
  // the index counts from January as zero.
  function automatic logic [DOY_W-1:0] month_offset(input logic [MIDX_W-1:0] idx);
    logic [DOY_W-1:0] res;
    case (idx)
      4'd0:    res = 9'd306;
      4'd1:    res = 9'd337;
      4'd2:    res = 9'd0;
      4'd3:    res = 9'd31;
      4'd4:    res = 9'd61;
      4'd5:    res = 9'd92;
      4'd6:    res = 9'd122;
      4'd7:    res = 9'd153;
      4'd8:    res = 9'd184;
      4'd9:    res = 9'd214;
      4'd10:   res = 9'd245;
      4'd11:   res = 9'd275;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/ctus_floor_div.sv
// ----------------------------------------------------------------------------
// ctus_floor_div: pipelined floor division by a constant
// Gives the floored quotient and the non-negative remainder of a signed
// word divided by D, through three register stages.
// ----------------------------------------------------------------------------
module ctus_floor_div #(
  parameter int unsigned W = 33,
  parameter int unsigned D = 12,
  localparam int unsigned RW = $clog2(D)
) (
  input  logic                clk,
  input  logic signed [W-1:0] x,
  output logic signed [W-1:0] q,
  output logic [RW-1:0]       r
);

  localparam int unsigned UW       = W - 1;
  localparam logic [63:0] MUL_FULL = (64'd1 << UW) / 64'(D);
  localparam int unsigned MW       = $clog2(MUL_FULL + 64'd1);
  localparam int unsigned PW       = UW + MW;
  localparam logic [MW-1:0] MUL    = MUL_FULL[MW-1:0];

  logic [UW-1:0] mag_c;
  logic [PW-1:0] prod_c;
  logic          neg1;
  logic [UW-1:0] mag1;
  logic [PW-1:0] prod1;

  logic [MW-1:0] quo0_c;
  logic [UW-1:0] rem0_c;
  logic          neg2;
  logic [MW-1:0] quo2;
  logic [RW:0]   rem2;

  logic          over_c;
  logic [MW-1:0] quo_c;
  logic [RW-1:0] rem_c;

  // A negative word x is folded to -x-1, whose floored quotient q gives
  // -q-1 for x; the reciprocal product then estimates the magnitude.
  assign mag_c  = x[W-1] ? ~x[UW-1:0] : x[UW-1:0];
  assign prod_c = PW'(mag_c) * PW'(MUL);

  always_ff @(posedge clk) begin
    neg1  <= x[W-1];
    mag1  <= mag_c;
    prod1 <= prod_c;
  end

  // The estimate is low by at most one, so the raw remainder is below 2D.
  assign quo0_c = prod1[PW-1:UW];
  assign rem0_c = mag1 - UW'(quo0_c) * UW'(D);

  always_ff @(posedge clk) begin
    neg2 <= neg1;
    quo2 <= quo0_c;
    rem2 <= rem0_c[RW:0];
  end

  // One correction step, then the sign is restored.
  assign over_c = rem2 >= (RW + 1)'(D);
  assign quo_c  = over_c ? quo2 + MW'(1) : quo2;
  assign rem_c  = over_c ? RW'(rem2 - (RW + 1)'(D)) : rem2[RW-1:0];

  always_ff @(posedge clk) begin
    q <= neg2 ? ~W'(quo_c) : W'(quo_c);
    r <= neg2 ? RW'(D - 1) - rem_c : rem_c;
  end

endmodule

FILE: hw/rtl/civil_time_to_unix_seconds.sv
// ----------------------------------------------------------------------------
// civil_time_to_unix_seconds: Gregorian UTC civil time to Unix seconds
// Converts year, month, day, hour, minute and second, each of any value,
// into seconds since the epoch, with a flag for clock or month carries.
// ----------------------------------------------------------------------------
// A word is taken at every clock edge at which start is high; busy is held
// low, so one conversion enters per cycle without gaps. Each result appears
// on unix_seconds and was_normalized with done high for one cycle, in the
// order taken, once its word has passed every register stage listed below.
// The receiver cannot stall the block and need not: every
// stage moves on every cycle. The ten register stages are three of the
// month carry divider by 12, three of the era divider by 400, the era day
// product, the day sum, the day-to-seconds product and the final add.
// Out-of-range days roll across months and years but do not raise
// was_normalized. Reset only clears the valid bits; nothing needs clearing
// before the first word.
module civil_time_to_unix_seconds (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ctus_pkg::FIELD_W-1:0]  civil_year,
  input  logic signed [ctus_pkg::FIELD_W-1:0]  civil_month,
  input  logic signed [ctus_pkg::FIELD_W-1:0]  civil_day,
  input  logic signed [ctus_pkg::FIELD_W-1:0]  civil_hour,
  input  logic signed [ctus_pkg::FIELD_W-1:0]  civil_minute,
  input  logic signed [ctus_pkg::FIELD_W-1:0]  civil_second,
  output logic                                 done,
  output logic signed [ctus_pkg::SECS_W-1:0]   unix_seconds,
  output logic                                 was_normalized
);

  import ctus_pkg::*;

  logic                          valid_q [1:9];
  side_t                         side_q  [2:9];
  logic [DOY_W-1:0]              doy_q   [4:6];

  logic signed [MONTH_DIV_W-1:0] month_m1_c;
  logic                          flag_sec_c;
  logic                          flag_mon_c;

  logic signed [FIELD_W-1:0]     s1_year;
  logic signed [DAY_ADJ_W-1:0]   s1_day_adj;
  logic signed [FIELD_W-1:0]     s1_sec;
  logic signed [MIN_SECS_W-1:0]  s1_min_secs;
  logic signed [HOUR_SECS_W-1:0] s1_hour_secs;
  logic                          s1_flag;

  logic signed [SOD_MIN_W-1:0]   sod_min_c;
  logic signed [SOD_W-1:0]       sod_c;
  logic                          flag_clock_c;

  logic signed [FIELD_W-1:0]     s2_year;
  logic signed [FIELD_W-1:0]     s3_year;

  logic signed [MONTH_DIV_W-1:0] year_carry;
  logic [MIDX_W-1:0]             month_idx;
  logic signed [MONTH_DIV_W-1:0] year1_c;
  logic                          jan_feb_c;
  logic signed [ERA_DIV_W-1:0]   yy_c;

  logic signed [ERA_DIV_W-1:0]   era_full;
  logic [YOE_W-1:0]              yoe;
  logic signed [ERA_W-1:0]       era_c;
  logic signed [ERA_DAYS_W-1:0]  era_days_c;
  logic [1:0]                    cent_c;
  logic [DOE_W-1:0]              doe_c;

  logic signed [ERA_DAYS_W-1:0]  s7_era_days;
  logic [DOE_W-1:0]              s7_doe;
  logic signed [DAYS_W-1:0]      days_c;
  logic signed [DAYS_W-1:0]      s8_days;
  logic signed [DAY_PROD_W-1:0]  prod_c;
  logic signed [DAY_PROD_W-1:0]  s9_prod;
  logic signed [SECS_W-1:0]      secs_c;

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy = 1'b0;

  // Valid bits travel with the words; the last one becomes the strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 9; i++) valid_q[i] <= 1'b0;
      done <= 1'b0;
    end else begin
      valid_q[1] <= start && !busy;
      for (int i = 2; i <= 9; i++) valid_q[i] <= valid_q[i-1];
      done <= valid_q[9];
    end
  end

  // Stage 0: zero-based month goes to the divider; out-of-range checks.
  assign month_m1_c = MONTH_DIV_W'(civil_month) - MONTH_DIV_W'(1);
  assign flag_sec_c = (civil_second < 32'sd0) ||
                      (civil_second >= FIELD_W'(SECS_PER_MINUTE));
  assign flag_mon_c = (civil_month < 32'sd1) ||
                      (civil_month > FIELD_W'(MONTHS_PER_YEAR));

  always_ff @(posedge clk) begin
    s1_year      <= civil_year;
    s1_day_adj   <= DAY_ADJ_W'(civil_day) - DAY_ADJ_W'(EPOCH_DAYS + 1);
    s1_sec       <= civil_second;
    s1_min_secs  <= MIN_SECS_W'(civil_minute) * MIN_SECS_W'(SECS_PER_MINUTE);
    s1_hour_secs <= HOUR_SECS_W'(civil_hour) * HOUR_SECS_W'(SECS_PER_HOUR);
    s1_flag      <= flag_sec_c || flag_mon_c;
  end

  ctus_floor_div #(
    .W (MONTH_DIV_W),
    .D (MONTHS_PER_YEAR)
  ) u_month_div (
    .clk (clk),
    .x   (month_m1_c),
    .q   (year_carry),
    .r   (month_idx)
  );

  // Stage 1: the clock fields summed to seconds. A minute carry happens
  // exactly when the seconds of the hour leave one hour, and an hour carry
  // when the seconds of the day leave one day.
  assign sod_min_c    = SOD_MIN_W'(s1_sec) + SOD_MIN_W'(s1_min_secs);
  assign sod_c        = SOD_W'(sod_min_c) + SOD_W'(s1_hour_secs);
  assign flag_clock_c = (sod_min_c < 0) || (sod_min_c >= SOD_MIN_W'(SECS_PER_HOUR)) ||
                        (sod_c < 0) || (sod_c >= SOD_W'(SECS_PER_DAY));

  always_ff @(posedge clk) begin
    s2_year   <= s1_year;
    s3_year   <= s2_year;
    side_q[2] <= '{day_adj: s1_day_adj, secs: sod_c, flag: s1_flag || flag_clock_c};
    for (int i = 3; i <= 9; i++) side_q[i] <= side_q[i-1];
  end

  // Stage 3: apply the year carry; January and February count with the
  // previous year so that the leap day ends the counting year.
  assign year1_c   = MONTH_DIV_W'(s3_year) + year_carry;
  assign jan_feb_c = month_idx < MIDX_W'(MARCH_INDEX);
  assign yy_c      = ERA_DIV_W'(year1_c) - ERA_DIV_W'(jan_feb_c);

  always_ff @(posedge clk) begin
    doy_q[4] <= month_offset(month_idx);
    doy_q[5] <= doy_q[4];
    doy_q[6] <= doy_q[5];
  end

  ctus_floor_div #(
    .W (ERA_DIV_W),
    .D (YEARS_PER_ERA)
  ) u_era_div (
    .clk (clk),
    .x   (yy_c),
    .q   (era_full),
    .r   (yoe)
  );

  // Stage 6: days of the whole eras and day of the era.
  assign era_c      = era_full[ERA_W-1:0];
  assign era_days_c = ERA_DAYS_W'(era_c) * ERA_DAYS_W'(DAYS_PER_ERA);
  assign cent_c     = (yoe >= 9'd300) ? 2'd3 :
                      (yoe >= 9'd200) ? 2'd2 :
                      (yoe >= 9'd100) ? 2'd1 : 2'd0;
  assign doe_c      = DOE_W'(yoe) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe[YOE_W-1:2]) -
                      DOE_W'(cent_c) + DOE_W'(doy_q[6]);

  always_ff @(posedge clk) begin
    s7_era_days <= era_days_c;
    s7_doe      <= doe_c;
  end

  // Stage 7: day count from the epoch, the day of month included.
  assign days_c = DAYS_W'(s7_era_days) + DAYS_W'(s7_doe) +
                  DAYS_W'($signed(side_q[7].day_adj));

  always_ff @(posedge clk) begin
    s8_days <= days_c;
  end

  // Stage 8: days scaled by the odd factor of a day's seconds.
  assign prod_c = DAY_PROD_W'(s8_days) * DAY_PROD_W'(DAY_MUL);

  always_ff @(posedge clk) begin
    s9_prod <= prod_c;
  end

  // Stage 9: the power-of-two factor and the seconds of the day.
  assign secs_c = (SECS_W'(s9_prod) <<< DAY_SHIFT) + SECS_W'($signed(side_q[9].secs));

  always_ff @(posedge clk) begin
    unix_seconds   <= secs_c;
    was_normalized <= side_q[9].flag;
  end

  // Every result word stems from an earlier word taken with start high.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 10))
    else $error("result word without a matching input word");

  // An unflagged result must have had a month in the calendar range.
  a_month_flag: assert property (@(posedge clk) disable iff (rst)
    done && !was_normalized |->
      $past((civil_month >= 32'sd1) && (civil_month <= 32'sd12), 10))
    else $error("month carry not flagged");

  // An unflagged result must have had a second within the minute.
  a_second_flag: assert property (@(posedge clk) disable iff (rst)
    done && !was_normalized |->
      $past((civil_second >= 32'sd0) && (civil_second <= 32'sd59), 10))
    else $error("second carry not flagged");

  // The year of the era leaving the divider stays within one era.
  a_yoe_range: assert property (@(posedge clk) disable iff (rst)
    valid_q[6] |-> (yoe < 9'd400))
    else $error("year of era out of range");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: checks the civil time to Unix seconds converter
// Sends civil time words through the start/busy handshake and checks every
// result strobed on done against a predictor in 64-bit arithmetic. The run
// covers calendar points, carries, extreme fields and random words, with
// and without gaps.
// ----------------------------------------------------------------------------
module testbench;

  import ctus_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [FIELD_W-1:0] year;
    logic signed [FIELD_W-1:0] month;
    logic signed [FIELD_W-1:0] day;
    logic signed [FIELD_W-1:0] hour;
    logic signed [FIELD_W-1:0] minute;
    logic signed [FIELD_W-1:0] second;
  } civil_word_t;

  typedef struct {
    logic signed [SECS_W-1:0] seconds;
    logic                     normalized;
  } epoch_result_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [FIELD_W-1:0] civil_year;
  logic signed [FIELD_W-1:0] civil_month;
  logic signed [FIELD_W-1:0] civil_day;
  logic signed [FIELD_W-1:0] civil_hour;
  logic signed [FIELD_W-1:0] civil_minute;
  logic signed [FIELD_W-1:0] civil_second;
  logic                      done;
  logic signed [SECS_W-1:0]  unix_seconds;
  logic                      was_normalized;

  epoch_result_t pending_epochs[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            no_gaps = 1'b0;

  civil_time_to_unix_seconds dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .civil_year     (civil_year),
    .civil_month    (civil_month),
    .civil_day      (civil_day),
    .civil_hour     (civil_hour),
    .civil_minute   (civil_minute),
    .civil_second   (civil_second),
    .done           (done),
    .unix_seconds   (unix_seconds),
    .was_normalized (was_normalized)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Floor division by a positive base: the value keeps the remainder, the
  // quotient is returned, and any nonzero quotient marks a carry.
  function automatic longint floor_carry(input longint base, inout longint v,
                                         inout bit carried);
    longint q;
    longint r;
    q = v / base;
    r = v % base;
    if (r < 0) begin
      q = q - 1;
      r = r + base;
    end
    v = r;
    if (q != 0) carried = 1'b1;
    return q;
  endfunction

  // Seconds since the epoch for one civil time word, with the carry flag.
  function automatic epoch_result_t epoch_of(input civil_word_t w);
    epoch_result_t res;
    longint yr, mo, dy, hr, mi, sc;
    longint yy, era, yoe, doy, doe, days;
    bit carried;
    yr = longint'(w.year);
    mo = longint'(w.month);
    dy = longint'(w.day);
    hr = longint'(w.hour);
    mi = longint'(w.minute);
    sc = longint'(w.second);
    carried = 1'b0;
    mi = mi + floor_carry(60, sc, carried);
    hr = hr + floor_carry(60, mi, carried);
    dy = dy + floor_carry(24, hr, carried);
    mo = mo - 1;
    yr = yr + floor_carry(12, mo, carried);
    mo = mo + 1;
    // Day count of the first of the month, years starting in March.
    yy = yr - ((mo <= 2) ? 1 : 0);
    era = ((yy >= 0) ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    doy = (153 * (mo + ((mo > 2) ? -3 : 9)) + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468 + dy - 1;
    res.seconds = ((days * 24 + hr) * 60 + mi) * 60 + sc;
    res.normalized = carried;
    return res;
  endfunction

  function automatic civil_word_t civil(input int y, input int m, input int d,
                                        input int h, input int mi, input int s);
    civil_word_t w;
    w.year = y;
    w.month = m;
    w.day = d;
    w.hour = h;
    w.minute = mi;
    w.second = s;
    return w;
  endfunction

  // Mostly in range, some just outside it, some anywhere in 32 bits.
  function automatic logic signed [FIELD_W-1:0] pick_field(input int lo, input int hi);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return lo + int'($urandom_range(0, hi - lo));
    else if (sel < 85) return lo - 200 + int'($urandom_range(0, hi - lo + 400));
    else return $urandom;
  endfunction

  function automatic civil_word_t random_civil_word();
    civil_word_t w;
    w.year = pick_field(-3000, 3000);
    w.month = pick_field(1, 12);
    w.day = pick_field(1, 31);
    w.hour = pick_field(0, 23);
    w.minute = pick_field(0, 59);
    w.second = pick_field(0, 59);
    return w;
  endfunction

  // Sends one word, with an occasional gap before it unless gaps are off.
  task automatic send_word(input civil_word_t w);
    while (!no_gaps && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    civil_year <= w.year;
    civil_month <= w.month;
    civil_day <= w.day;
    civil_hour <= w.hour;
    civil_minute <= w.minute;
    civil_second <= w.second;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_epochs.push_back(epoch_of(w));
  endtask

  task automatic wait_for_results();
    while (pending_epochs.size() != 0) @(posedge clk);
  endtask

  task automatic test_calendar_points();
    send_word(civil(1970, 1, 1, 0, 0, 0));
    send_word(civil(2000, 2, 29, 12, 34, 56));
    send_word(civil(1900, 3, 1, 0, 0, 0));
    send_word(civil(0, 1, 1, 0, 0, 0));
    send_word(civil(-1, 12, 31, 23, 59, 59));
    send_word(civil(1969, 12, 31, 23, 59, 59));
    send_word(civil(2038, 1, 19, 3, 14, 8));
    send_word(civil(9999, 12, 31, 23, 59, 59));
  endtask

  // Clock and month carries raise the flag; day roll-over does not.
  task automatic test_field_carries();
    send_word(civil(2024, 6, 15, 10, 20, -1));
    send_word(civil(2024, 6, 15, 10, 20, 60));
    send_word(civil(2024, 6, 15, 10, -1, 30));
    send_word(civil(2024, 6, 15, 10, 60, 30));
    send_word(civil(2024, 6, 15, 24, 0, 0));
    send_word(civil(2024, 6, 15, -1, 0, 0));
    send_word(civil(2024, 13, 1, 0, 0, 0));
    send_word(civil(2024, 0, 1, 0, 0, 0));
    send_word(civil(2023, 1, 32, 0, 0, 0));
    send_word(civil(2024, 3, 0, 0, 0, 0));
    send_word(civil(2024, 3, -400, 0, 0, 0));
  endtask

  task automatic test_field_extremes();
    send_word(civil(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    send_word(civil(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    send_word(civil(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    send_word(civil(FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    send_word(civil(FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX));
  endtask

  task automatic test_random_with_gaps();
    repeat (700) send_word(random_civil_word());
  endtask

  // A long run of words on consecutive cycles.
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (400) send_word(random_civil_word());
    no_gaps = 1'b0;
  endtask

  // The sender stops until the pipeline has emptied, then carries on.
  task automatic test_drain_pause();
    repeat (150) send_word(random_civil_word());
    start <= 1'b0;
    wait_for_results();
    repeat (150) send_word(random_civil_word());
  endtask

  // Stimulus: reset once, then each test in turn, then drain and report.
  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    civil_year <= '0;
    civil_month <= '0;
    civil_day <= '0;
    civil_hour <= '0;
    civil_minute <= '0;
    civil_second <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_calendar_points();
    test_field_carries();
    test_field_extremes();
    test_random_with_gaps();
    test_back_to_back();
    test_drain_pause();
    start <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_epochs.size() != 0) begin
      $error("%0d results never arrived", pending_epochs.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Each strobed result is checked against the oldest outstanding word.
  always @(posedge clk) begin
    epoch_result_t exp_res;
    if (!rst && done) begin
      if (pending_epochs.size() == 0) begin
        $error("result with no word outstanding: unix_seconds %0d", unix_seconds);
        error_count++;
      end else begin
        exp_res = pending_epochs.pop_front();
        if (unix_seconds !== exp_res.seconds) begin
          $error("unix_seconds: expected %0d, got %0d", exp_res.seconds, unix_seconds);
          error_count++;
        end
        if (was_normalized !== exp_res.normalized) begin
          $error("was_normalized: expected %0d, got %0d", exp_res.normalized,
                 was_normalized);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

endmodule
